// ===== rtl/mrba_pkg.sv =====
package mrba_pkg;

  // operation and size codes
  localparam logic       OP_READ   = 1'b0;
  localparam logic       OP_WRITE  = 1'b1;
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_MIRROR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAVE_MIRROR = 2'd1;

  // region codes
  localparam logic [3:0] REG_BOARD    = 4'd0;
  localparam logic [3:0] REG_CHIP     = 4'd1;
  localparam logic [3:0] REG_IO       = 4'd2;
  localparam logic [3:0] REG_PAL      = 4'd3;
  localparam logic [3:0] REG_VID      = 4'd4;
  localparam logic [3:0] REG_ATTR     = 4'd5;
  localparam logic [3:0] REG_ROM0     = 4'd6;
  localparam logic [3:0] REG_ROM1     = 4'd7;
  localparam logic [3:0] REG_ROM2     = 4'd8;
  localparam logic [3:0] REG_ROM3     = 4'd9;
  localparam logic [3:0] REG_ROM4     = 4'd10;
  localparam logic [3:0] REG_ROM5     = 4'd11;
  localparam logic [3:0] REG_SAVE     = 4'd12;
  localparam logic [3:0] REG_UNMAPPED = 4'd13;

  // fixed store sizes
  localparam logic [25:0] BOARD_BYTES = 26'h0040000;
  localparam logic [25:0] CHIP_BYTES  = 26'h0008000;
  localparam logic [25:0] IO_BYTES    = 26'h0000400;
  localparam logic [25:0] PAL_BYTES   = 26'h0000400;
  localparam logic [25:0] VID_BYTES   = 26'h0018000;
  localparam logic [25:0] ATTR_BYTES  = 26'h0000400;

  // base of each cleared store inside the shared byte memory
  localparam logic [31:0] BOARD_BASE = 32'h00000000;
  localparam logic [31:0] CHIP_BASE  = 32'h00040000;
  localparam logic [31:0] IO_BASE    = 32'h00048000;
  localparam logic [31:0] PAL_BASE   = 32'h00048400;
  localparam logic [31:0] VID_BASE   = 32'h00048800;
  localparam logic [31:0] ATTR_BASE  = 32'h00060800;
  localparam logic [31:0] SAVE_BASE  = 32'h00060C00;
  localparam int unsigned FIXED_BYTES = 32'h00060C00;

  localparam int unsigned ROM_BYTES_DEF  = 33554432;
  localparam int unsigned SAVE_BYTES_DEF = 65536;

  localparam logic [25:0] ROM_MIRROR_RST  = 26'h2000000;
  localparam logic [16:0] SAVE_MIRROR_RST = 17'h10000;

  typedef struct packed {
    logic        operation;
    logic [1:0]  size;
    logic [31:0] address;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] bus_data;
    logic [3:0]  region;
    logic [24:0] offset;
  } res_t;

endpackage

// ===== rtl/mrba_ram.sv =====
module mrba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ===== rtl/mrba_mod.sv =====
module mrba_mod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [25:0] divisor_i,
  output logic        done_o,
  output logic [24:0] rem_o
);

  // restoring remainder, one dividend bit per cycle
  logic        run_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] dvd_q;
  logic [25:0] dsr_q, rem_q;
  logic [26:0] trial, diff;
  logic [25:0] rem_n;

  assign trial = {rem_q, dvd_q[31]};
  assign diff  = trial - {1'b0, dsr_q};
  assign rem_n = (trial >= {1'b0, dsr_q}) ? diff[25:0] : trial[25:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      rem_q <= rem_n;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[24:0];

endmodule

// ===== rtl/mirrored_region_bus_access_core.sv =====
// Bus access core for a handheld memory map with mirrored regions. start_i is
// taken when busy_o is low; each access gives exactly one result, shown for
// one cycle with res_valid_o, and the receiver cannot stall it. An unmapped
// access answers in the cycle after it is taken. A mapped access runs a shared
// bit-serial modulo unit (one address bit a cycle) and then moves one byte
// lane a cycle through a byte-wide memory, 1, 2 or 4 bytes by size. After
// reset the cleared stores, FIXED_BYTES + SAVE_BYTES bytes (461824 at the
// default sizes), are swept to zero with busy_o high; configuration writes are
// always taken.
module mirrored_region_bus_access_core #(
  parameter int unsigned ROM_BYTES  = mrba_pkg::ROM_BYTES_DEF,
  parameter int unsigned SAVE_BYTES = mrba_pkg::SAVE_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  mrba_pkg::req_t                 req_i,
  output logic                           res_valid_o,
  output mrba_pkg::res_t                 res_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mrba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);

  localparam int unsigned CLR_DEPTH = mrba_pkg::FIXED_BYTES + SAVE_BYTES;
  localparam int unsigned CLR_AW    = $clog2(CLR_DEPTH);
  localparam int unsigned ROM_AW    = $clog2(ROM_BYTES);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DIV   = 5'b00100,
    S_ACC   = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [25:0] rom_mirror_q;
  logic [16:0] save_mirror_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_mirror_q  <= mrba_pkg::ROM_MIRROR_RST;
      save_mirror_q <= mrba_pkg::SAVE_MIRROR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mrba_pkg::CFG_ROM_MIRROR:  rom_mirror_q  <= cfg_data_i[25:0];
        mrba_pkg::CFG_SAVE_MIRROR: save_mirror_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // clamped mirror sizes, zero acts as one
  logic [25:0] rom_m, save_m;

  always_comb begin
    rom_m = rom_mirror_q;
    if (rom_mirror_q == 26'd0) begin
      rom_m = 26'd1;
    end else if (rom_mirror_q > 26'(ROM_BYTES)) begin
      rom_m = 26'(ROM_BYTES);
    end
    save_m = {9'd0, save_mirror_q};
    if (save_mirror_q == 17'd0) begin
      save_m = 26'd1;
    end else if (save_mirror_q > 17'(SAVE_BYTES)) begin
      save_m = 26'(SAVE_BYTES);
    end
  end

  // region decode of the incoming address
  logic [7:0]  top;
  logic        mapped;
  logic [3:0]  region_in;
  logic [25:0] mirror_in;
  logic [31:0] base_in;
  logic        rom_in;

  assign top       = req_i.address[31:24];
  assign mapped    = (top >= 8'd2) && (top <= 8'd14);
  assign region_in = 4'(top - 8'd2);

  always_comb begin
    rom_in = 1'b0;
    unique case (region_in) inside
      mrba_pkg::REG_BOARD: begin
        mirror_in = mrba_pkg::BOARD_BYTES;
        base_in   = mrba_pkg::BOARD_BASE;
      end
      mrba_pkg::REG_CHIP: begin
        mirror_in = mrba_pkg::CHIP_BYTES;
        base_in   = mrba_pkg::CHIP_BASE;
      end
      mrba_pkg::REG_IO: begin
        mirror_in = mrba_pkg::IO_BYTES;
        base_in   = mrba_pkg::IO_BASE;
      end
      mrba_pkg::REG_PAL: begin
        mirror_in = mrba_pkg::PAL_BYTES;
        base_in   = mrba_pkg::PAL_BASE;
      end
      mrba_pkg::REG_VID: begin
        mirror_in = mrba_pkg::VID_BYTES;
        base_in   = mrba_pkg::VID_BASE;
      end
      mrba_pkg::REG_ATTR: begin
        mirror_in = mrba_pkg::ATTR_BYTES;
        base_in   = mrba_pkg::ATTR_BASE;
      end
      mrba_pkg::REG_ROM0, mrba_pkg::REG_ROM1, mrba_pkg::REG_ROM2,
      mrba_pkg::REG_ROM3, mrba_pkg::REG_ROM4, mrba_pkg::REG_ROM5: begin
        mirror_in = rom_m;
        base_in   = 32'd0;
        rom_in    = 1'b1;
      end
      default: begin
        // save ram, and codes past the map which never get this far
        mirror_in = save_m;
        base_in   = mrba_pkg::SAVE_BASE;
      end
    endcase
  end

  // offset by the shared modulo unit
  logic        accept, mod_start, mod_done;
  logic [24:0] mod_rem;

  assign accept    = start_i && (state_q == S_IDLE);
  assign mod_start = accept && mapped;

  mrba_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (req_i.address),
    .divisor_i  (mirror_in),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // item registers
  mrba_pkg::req_t req_q;
  logic [3:0]  region_q;
  logic [25:0] mirror_q;
  logic [CLR_AW-1:0] base_q;
  logic        rom_q;
  logic [24:0] off_q, off_d, cur_q, cur_d;
  logic [1:0]  lane_q, lane_d, pend_lane_q, nlast;
  logic        pend_q, pend_d;
  logic [31:0] data_q, data_d, latch_q, latch_d;
  logic [CLR_AW-1:0] clr_q, clr_d;
  mrba_pkg::res_t res_q, res_d;
  logic        res_valid_q, res_valid_d;

  // memories: cleared stores share one, the rom has its own
  logic              access, is_write;
  logic              clr_we, rom_we;
  logic [CLR_AW-1:0] clr_addr;
  logic [7:0]        clr_wdata, clr_rdata, rom_rdata, rdata, lane_byte;
  logic [25:0]       cur_inc;

  assign is_write  = (req_q.operation == mrba_pkg::OP_WRITE);
  assign access    = (state_q == S_ACC);
  assign lane_byte = req_q.write_data[{lane_q, 3'b000} +: 8];
  assign clr_we    = (state_q == S_CLEAR) || (access && is_write && !rom_q);
  assign rom_we    = access && is_write && rom_q;
  assign clr_addr  = (state_q == S_CLEAR) ? clr_q : CLR_AW'(base_q + CLR_AW'(cur_q));
  assign clr_wdata = (state_q == S_CLEAR) ? 8'd0 : lane_byte;
  assign rdata     = rom_q ? rom_rdata : clr_rdata;
  assign cur_inc   = {1'b0, cur_q} + 26'd1;

  mrba_ram #(.WIDTH(8), .DEPTH(CLR_DEPTH)) u_clr_ram (
    .clk_i   (clk_i),
    .we_i    (clr_we),
    .addr_i  (clr_addr),
    .wdata_i (clr_wdata),
    .rdata_o (clr_rdata)
  );

  mrba_ram #(.WIDTH(8), .DEPTH(ROM_BYTES)) u_rom_ram (
    .clk_i   (clk_i),
    .we_i    (rom_we),
    .addr_i  (cur_q[ROM_AW-1:0]),
    .wdata_i (lane_byte),
    .rdata_o (rom_rdata)
  );

  always_comb begin
    case (req_q.size)
      mrba_pkg::SIZE_BYTE: nlast = 2'd0;
      mrba_pkg::SIZE_HALF: nlast = 2'd1;
      default:             nlast = 2'd3;
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    off_d       = off_q;
    lane_d      = lane_q;
    pend_d      = 1'b0;
    data_d      = data_q;
    latch_d     = latch_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    // read byte lands in the cycle after its address
    if (pend_q) begin
      data_d[{pend_lane_q, 3'b000} +: 8] = rdata;
    end
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + CLR_AW'(1);
        if (clr_q == CLR_AW'(CLR_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          data_d = '0;
          lane_d = '0;
          if (mapped) begin
            state_d = S_DIV;
          end else begin
            res_d.bus_data = latch_q;
            res_d.region   = mrba_pkg::REG_UNMAPPED;
            res_d.offset   = '0;
            res_valid_d    = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (mod_done) begin
          off_d   = mod_rem;
          cur_d   = mod_rem;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        pend_d = !is_write;
        // step to the next byte, wrapping at the mirror size
        cur_d  = (cur_inc == mirror_q) ? 25'd0 : cur_inc[24:0];
        lane_d = lane_q + 2'd1;
        if (lane_q == nlast) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        latch_d        = is_write ? req_q.write_data : data_d;
        res_d.bus_data = latch_d;
        res_d.region   = region_q;
        res_d.offset   = off_q;
        res_valid_d    = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
      latch_q     <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      latch_q     <= latch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= req_i;
      region_q <= region_in;
      mirror_q <= mirror_in;
      base_q   <= CLR_AW'(base_in);
      rom_q    <= rom_in;
    end
    cur_q       <= cur_d;
    off_q       <= off_d;
    lane_q      <= lane_d;
    pend_lane_q <= lane_q;
    data_q      <= data_d;
    res_q       <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTH
  // a result always leaves the core ready for the next transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid_o |-> !busy_o)
    else $error("result shown while busy");

  // every accepted access either starts work or answers at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || res_valid_o))
    else $error("accepted access dropped");

  // unmapped answers carry a zero offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.region == mrba_pkg::REG_UNMAPPED)) |-> (res_o.offset == 25'd0))
    else $error("unmapped offset not zero");

  // the byte pointer stays inside the mirror
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> ({1'b0, cur_q} < mirror_q))
    else $error("byte pointer past mirror");
`endif

endmodule

// ===== sim/testbench.sv =====
module testbench;

  localparam int unsigned WATCHDOG_LIMIT = 1500000;
  localparam int unsigned HIST_DEPTH     = 64;
  localparam int unsigned ITEMS_PER_PHASE = 125;

  // stimulus row of the directed part; chk marks a hand-typed expectation
  typedef struct {
    logic        op;
    logic [1:0]  size;
    logic [31:0] addr;
    logic [31:0] wdata;
    bit          chk;
    logic [31:0] bus;
    logic [3:0]  region;
    logic [24:0] offset;
  } row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  logic           busy_o;
  mrba_pkg::req_t req_i = '0;
  logic           res_valid_o;
  mrba_pkg::res_t res_o;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [mrba_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]    cfg_data_i = '0;

  // predictor state: sparse byte stores, key = store id << 26 | byte index
  logic [7:0]  mem_model [longint unsigned];
  bit          rom_written [longint unsigned];
  logic [31:0] latch_model;
  logic [25:0] rom_mirror_reg;
  logic [16:0] save_mirror_reg;

  mrba_pkg::res_t expected_results [$];
  logic [31:0] recent_addrs [$];
  int unsigned n_fail = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_unmapped = 0;
  int unsigned n_cfg = 0;
  int unsigned idle_cycles = 0;

  mirrored_region_bus_access_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // effective mirror size of a region, registers clamped to the store depth
  function automatic logic [25:0] mirror_of(logic [3:0] region);
    case (region)
      mrba_pkg::REG_BOARD: return mrba_pkg::BOARD_BYTES;
      mrba_pkg::REG_CHIP:  return mrba_pkg::CHIP_BYTES;
      mrba_pkg::REG_IO:    return mrba_pkg::IO_BYTES;
      mrba_pkg::REG_PAL:   return mrba_pkg::PAL_BYTES;
      mrba_pkg::REG_VID:   return mrba_pkg::VID_BYTES;
      mrba_pkg::REG_ATTR:  return mrba_pkg::ATTR_BYTES;
      mrba_pkg::REG_SAVE: begin
        if (save_mirror_reg == 17'd0) return 26'd1;
        if (save_mirror_reg > mrba_pkg::SAVE_BYTES_DEF)
          return 26'(mrba_pkg::SAVE_BYTES_DEF);
        return {9'd0, save_mirror_reg};
      end
      default: begin
        if (rom_mirror_reg == 26'd0) return 26'd1;
        if (rom_mirror_reg > mrba_pkg::ROM_BYTES_DEF)
          return 26'(mrba_pkg::ROM_BYTES_DEF);
        return rom_mirror_reg;
      end
    endcase
  endfunction

  // all rom aliases share one store
  function automatic longint unsigned store_key(logic [3:0] region, logic [25:0] idx);
    longint unsigned sid;
    sid = (region >= mrba_pkg::REG_ROM0 && region <= mrba_pkg::REG_ROM5) ? 64'd6 :
          (region == mrba_pkg::REG_SAVE) ? 64'd7 : {60'd0, region};
    return (sid << 26) | {38'd0, idx};
  endfunction

  function automatic int unsigned lane_count(logic [1:0] size);
    return (size == mrba_pkg::SIZE_BYTE) ? 1 : (size == mrba_pkg::SIZE_HALF) ? 2 : 4;
  endfunction

  function automatic bit is_mapped(logic [31:0] addr);
    return addr[31:24] >= 8'd2 && addr[31:24] <= 8'd14;
  endfunction

  // true when every rom byte a read would touch has been stored before
  function automatic bit rom_lanes_known(logic [31:0] addr, logic [1:0] size);
    logic [3:0]  region;
    logic [25:0] m;
    logic [25:0] off;
    region = 4'(addr[31:24] - 8'd2);
    m = mirror_of(region);
    off = 26'(addr % m);
    for (int i = 0; i < lane_count(size); i++)
      if (!rom_written.exists(store_key(region, 26'((off + i) % m)))) return 1'b0;
    return 1'b1;
  endfunction

  // computes the result of one bus access and updates the stores and latch
  function automatic mrba_pkg::res_t bus_access(mrba_pkg::req_t r);
    mrba_pkg::res_t res;
    logic [3:0]  region;
    logic [25:0] m;
    logic [25:0] off;
    logic [25:0] idx;
    logic [31:0] v;
    longint unsigned k;
    res = '0;
    if (!is_mapped(r.address)) begin
      res.bus_data = latch_model;
      res.region = mrba_pkg::REG_UNMAPPED;
      return res;
    end
    region = 4'(r.address[31:24] - 8'd2);
    m = mirror_of(region);
    off = 26'(r.address % m);
    v = '0;
    for (int i = 0; i < lane_count(r.size); i++) begin
      idx = 26'((off + i) % m);
      k = store_key(region, idx);
      if (r.operation == mrba_pkg::OP_WRITE) begin
        mem_model[k] = r.write_data[8*i +: 8];
        if (region >= mrba_pkg::REG_ROM0 && region <= mrba_pkg::REG_ROM5)
          rom_written[k] = 1'b1;
      end else if (mem_model.exists(k)) begin
        v[8*i +: 8] = mem_model[k];
      end
    end
    latch_model = (r.operation == mrba_pkg::OP_WRITE) ? r.write_data : v;
    res.bus_data = latch_model;
    res.region = region;
    res.offset = off[24:0];
    return res;
  endfunction

  task automatic write_cfg(logic [mrba_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == mrba_pkg::CFG_ROM_MIRROR) rom_mirror_reg = data[25:0];
    else save_mirror_reg = data[16:0];
    n_cfg++;
    @(posedge clk_i);
  endtask

  // one command transfer; start stays high across back-to-back transfers
  task automatic issue(mrba_pkg::req_t r, int unsigned gap, bit typed,
                       mrba_pkg::res_t typed_res);
    mrba_pkg::res_t pred;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    pred = bus_access(r);
    expected_results.push_back(typed ? typed_res : pred);
    n_items++;
    if (is_mapped(r.address)) begin
      recent_addrs.push_back(r.address);
      if (recent_addrs.size() > HIST_DEPTH) void'(recent_addrs.pop_front());
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // random access, weighted towards mapped regions, reused addresses and wraps
  function automatic mrba_pkg::req_t random_access();
    mrba_pkg::req_t r;
    logic [3:0]  region;
    logic [25:0] m;
    logic [25:0] tgt;
    int unsigned pick;
    r.operation = 1'($urandom_range(0, 1));
    r.size = 2'($urandom_range(0, 3));
    r.write_data = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 40 && recent_addrs.size() != 0) begin
      r.address = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
      r.address[1:0] = 2'($urandom_range(0, 3));
    end else if (pick < 90) begin
      r.address = {8'($urandom_range(2, 14)), 24'($urandom)};
      if (pick >= 70) begin
        // steer the first lane onto the last bytes of the mirror
        region = 4'(r.address[31:24] - 8'd2);
        m = mirror_of(region);
        tgt = m - 26'd1 - 26'($urandom_range(0, 2));
        r.address = r.address + 32'((tgt + m - 26'(r.address % m)) % m);
      end
    end else begin
      r.address = $urandom;
    end
    // never read rom bytes that were never stored
    if (is_mapped(r.address) && r.address[31:24] >= 8'd8 && r.address[31:24] <= 8'd13 &&
        r.operation == mrba_pkg::OP_READ && !rom_lanes_known(r.address, r.size))
      r.operation = mrba_pkg::OP_WRITE;
    return r;
  endfunction

  // result checker, one strobed result per cycle at most
  always @(posedge clk_i) begin
    mrba_pkg::res_t exp_res;
    if (rst_ni && res_valid_o) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: bus_data %h region %0d offset %h",
               res_o.bus_data, res_o.region, res_o.offset);
        n_fail++;
      end else begin
        exp_res = expected_results.pop_front();
        if (exp_res.region == mrba_pkg::REG_UNMAPPED) n_unmapped++;
        if (res_o.bus_data !== exp_res.bus_data) begin
          $error("bus_data expected %h actual %h", exp_res.bus_data, res_o.bus_data);
          n_fail++;
        end
        if (res_o.region !== exp_res.region) begin
          $error("region expected %0d actual %0d", exp_res.region, res_o.region);
          n_fail++;
        end
        if (res_o.offset !== exp_res.offset) begin
          $error("offset expected %h actual %h", exp_res.offset, res_o.offset);
          n_fail++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer of any kind, long enough for the sweep
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || (cfg_valid_i && cfg_ready_o) || res_valid_o)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("mirrored_region_bus_access_core: mismatch");
      $finish;
    end
  end

  initial begin
    row_t           rows [$];
    mrba_pkg::req_t r;
    mrba_pkg::res_t tr;
    int unsigned    gap;
    bit             burst;
    logic [31:0]    rom_set [6];
    logic [31:0]    save_set [6];

    latch_model = '0;
    rom_mirror_reg = mrba_pkg::ROM_MIRROR_RST;
    save_mirror_reg = mrba_pkg::SAVE_MIRROR_RST;

    // directed rows: reset contents, lane wrap, aliases, unmapped, size three
    rows = '{
      '{mrba_pkg::OP_READ,  2'd0, 32'h02000000, 32'h0, 1'b1, 32'h00000000,
        mrba_pkg::REG_BOARD, 25'h0},
      '{mrba_pkg::OP_READ,  2'd2, 32'h00000000, 32'h0, 1'b1, 32'h00000000,
        mrba_pkg::REG_UNMAPPED, 25'h0},
      '{mrba_pkg::OP_WRITE, 2'd2, 32'h03000000, 32'hDEADBEEF, 1'b1, 32'hDEADBEEF,
        mrba_pkg::REG_CHIP, 25'h0},
      '{mrba_pkg::OP_READ,  2'd0, 32'h03000000, 32'h0, 1'b1, 32'h000000EF,
        mrba_pkg::REG_CHIP, 25'h0},
      '{mrba_pkg::OP_READ,  2'd1, 32'h03000001, 32'h0, 1'b1, 32'h0000ADBE,
        mrba_pkg::REG_CHIP, 25'h1},
      '{mrba_pkg::OP_READ,  2'd0, 32'h01FFFFFF, 32'h0, 1'b1, 32'h0000ADBE,
        mrba_pkg::REG_UNMAPPED, 25'h0},
      '{mrba_pkg::OP_WRITE, 2'd1, 32'h03007FFF, 32'h12345678, 1'b1, 32'h12345678,
        mrba_pkg::REG_CHIP, 25'h7FFF},
      '{mrba_pkg::OP_READ,  2'd2, 32'h03000000, 32'h0, 1'b1, 32'hDEADBE56,
        mrba_pkg::REG_CHIP, 25'h0},
      '{mrba_pkg::OP_READ,  2'd3, 32'h03007FFF, 32'h0, 1'b1, 32'hADBE5678,
        mrba_pkg::REG_CHIP, 25'h7FFF},
      '{mrba_pkg::OP_WRITE, 2'd2, 32'h06017FFF, 32'hA1B2C3D4, 1'b1, 32'hA1B2C3D4,
        mrba_pkg::REG_VID, 25'h17FFF},
      '{mrba_pkg::OP_READ,  2'd0, 32'h06018000, 32'h0, 1'b1, 32'h000000C3,
        mrba_pkg::REG_VID, 25'h0},
      '{mrba_pkg::OP_WRITE, 2'd2, 32'h08000000, 32'h01020304, 1'b1, 32'h01020304,
        mrba_pkg::REG_ROM0, 25'h0},
      '{mrba_pkg::OP_READ,  2'd2, 32'h0A000000, 32'h0, 1'b1, 32'h01020304,
        mrba_pkg::REG_ROM2, 25'h0},
      '{mrba_pkg::OP_WRITE, 2'd0, 32'h0E00FFFF, 32'h00000055, 1'b1, 32'h00000055,
        mrba_pkg::REG_SAVE, 25'hFFFF},
      '{mrba_pkg::OP_READ,  2'd2, 32'h0E00FFFF, 32'h0, 1'b1, 32'h00000055,
        mrba_pkg::REG_SAVE, 25'hFFFF},
      '{mrba_pkg::OP_READ,  2'd2, 32'h0F000000, 32'h0, 1'b1, 32'h00000055,
        mrba_pkg::REG_UNMAPPED, 25'h0},
      '{mrba_pkg::OP_WRITE, 2'd2, 32'hFFFFFFFF, 32'h0, 1'b1, 32'h00000055,
        mrba_pkg::REG_UNMAPPED, 25'h0},
      '{mrba_pkg::OP_WRITE, 2'd2, 32'h04000000, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF,
        mrba_pkg::REG_IO, 25'h0},
      '{mrba_pkg::OP_READ,  2'd1, 32'h05000000, 32'h0, 1'b1, 32'h00000000,
        mrba_pkg::REG_PAL, 25'h0},
      '{mrba_pkg::OP_WRITE, 2'd0, 32'h070003FF, 32'h000000AA, 1'b1, 32'h000000AA,
        mrba_pkg::REG_ATTR, 25'h3FF},
      '{mrba_pkg::OP_WRITE, 2'd2, 32'h0D000000, 32'hCAFEF00D, 1'b0, '0, '0, '0},
      '{mrba_pkg::OP_READ,  2'd1, 32'h09000000, 32'h0, 1'b0, '0, '0, '0},
      '{mrba_pkg::OP_WRITE, 2'd3, 32'h02FFFFFF, 32'h87654321, 1'b0, '0, '0, '0},
      '{mrba_pkg::OP_READ,  2'd2, 32'h02FFFFFE, 32'h0, 1'b0, '0, '0, '0}
    };

    // mirror settings per random phase: minimum, zero, odd, over the top, mixed
    rom_set  = '{32'd1, 32'h0, 32'd3, 32'hFFFFFFFF, 32'h02000000, 32'h00100001};
    save_set = '{32'd1, 32'h0, 32'd7, 32'hFFFFFFFF, 32'h00010000, 32'd512};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // both registers at their reset values, taken even during the clearing sweep
    write_cfg(mrba_pkg::CFG_ROM_MIRROR, 32'(mrba_pkg::ROM_MIRROR_RST));
    write_cfg(mrba_pkg::CFG_SAVE_MIRROR, 32'(mrba_pkg::SAVE_MIRROR_RST));

    foreach (rows[i]) begin
      r.operation = rows[i].op;
      r.size = rows[i].size;
      r.address = rows[i].addr;
      r.write_data = rows[i].wdata;
      tr.bus_data = rows[i].bus;
      tr.region = rows[i].region;
      tr.offset = rows[i].offset;
      issue(r, $urandom_range(0, 7), rows[i].chk, tr);
    end
    drain();

    for (int p = 0; p < 7; p++) begin
      if (p < 6) begin
        write_cfg(mrba_pkg::CFG_ROM_MIRROR, rom_set[p]);
        write_cfg(mrba_pkg::CFG_SAVE_MIRROR, save_set[p]);
      end else begin
        write_cfg(mrba_pkg::CFG_ROM_MIRROR, $urandom_range(1, 33554432));
        write_cfg(mrba_pkg::CFG_SAVE_MIRROR, $urandom_range(1, 65536));
      end
      burst = 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // alternate stretches of back-to-back transfers with random gaps
        if ($urandom_range(0, 19) == 0) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 7);
        issue(random_access(), gap, 1'b0, '0);
      end
      drain();
    end

    $display("covered %0d accesses (%0d unmapped), %0d results, %0d register writes",
             n_items, n_unmapped, n_results, n_cfg);
    $display("mirror settings from one byte to beyond the store depth, zero included");
    if (n_fail == 0 && expected_results.size() == 0) begin
      $display("mirrored_region_bus_access_core: match");
    end else begin
      $display("mirrored_region_bus_access_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mrba_pkg.sv
rtl/mrba_ram.sv
rtl/mrba_mod.sv
rtl/mirrored_region_bus_access_core.sv
sim/testbench.sv
